### hdl/association_record_field_extractor_macros.svh
// ----------------------------------------------------------------------------
// association_record_field_extractor_macros
// Assertion helper macros for the record field extractor.
// ----------------------------------------------------------------------------
`ifndef ASSOCIATION_RECORD_FIELD_EXTRACTOR_MACROS_SVH
`define ASSOCIATION_RECORD_FIELD_EXTRACTOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ARFE_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define ARFE_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

### hdl/arfe_pkg.sv
// ----------------------------------------------------------------------------
// arfe_pkg
// Types, constants and key tables for the record field extractor.
// ----------------------------------------------------------------------------
package arfe_pkg;

   localparam int TEXT_LIMIT_MAX_DEFAULT = 255;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_payload;
   } req_payload_type;

   typedef struct packed {
      logic               result_kind;
      logic [1:0]         text_field;
      logic [7:0]         text_byte;
      logic [3:0]         status;
      logic signed [31:0] patient_number;
      logic signed [31:0] triage_value;
      logic [31:0]        reception_time;
      logic [31:0]        last_visit_time;
   } rsp_payload_type;

   // Sub-phases within one field.
   localparam logic [2:0] SUB_KEY   = 3'd0;
   localparam logic [2:0] SUB_COLON = 3'd1;
   localparam logic [2:0] SUB_WS    = 3'd2;
   localparam logic [2:0] SUB_VALUE = 3'd4;
   localparam logic [2:0] SUB_AFTER = 3'd6;
   localparam logic [5:0] PH_TAIL   = 6'd56;
   localparam logic [5:0] PH_DONE   = 6'd57;

   // Status codes.
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_KEY_MISSING = 4'd1;
   localparam logic [3:0] ST_COLON       = 4'd2;
   localparam logic [3:0] ST_NO_DIGITS   = 4'd3;
   localparam logic [3:0] ST_COMMA       = 4'd4;
   localparam logic [3:0] ST_NOT_STRING  = 4'd5;
   localparam logic [3:0] ST_TOO_LONG    = 4'd6;
   localparam logic [3:0] ST_UNTERM      = 4'd7;
   localparam logic [3:0] ST_TOO_LARGE   = 4'd8;
   localparam logic [3:0] ST_BRACE       = 4'd9;
   localparam logic [3:0] ST_TRAILING    = 4'd10;

   localparam logic RK_CHAR    = 1'b0;
   localparam logic RK_SUMMARY = 1'b1;

   // Register indexes.
   localparam logic [1:0] REG_SSN     = 2'd0;
   localparam logic [1:0] REG_NAME    = 2'd1;
   localparam logic [1:0] REG_SURNAME = 2'd2;

   localparam logic [7:0] CH_QUOTE = 8'h22;

   function automatic logic [4:0] key_len(input logic [2:0] f);
      case (f)
         3'd0:    return 5'd10;
         3'd1:    return 5'd3;
         3'd2:    return 5'd4;
         3'd3:    return 5'd7;
         3'd4:    return 5'd11;
         3'd5:    return 5'd19;
         3'd6:    return 5'd20;
         default: return 5'd0;
      endcase
   endfunction

   // Character p of the quoted key of field f (quote at both ends).
   function automatic logic [7:0] key_char(input logic [2:0] f, input logic [4:0] p);
      logic [8*20-1:0] s;
      logic [4:0]      i;
      s = '0;
      case (f)
         3'd0:    s = {"PATIENT_", "ID", 80'd0};
         3'd1:    s = {"SSN", 136'd0};
         3'd2:    s = {"NAME", 128'd0};
         3'd3:    s = {"SURNAME", 104'd0};
         3'd4:    s = {"TRIAGE_", "CODE", 72'd0};
         3'd5:    s = {"RECEPTION_", "TIMESTAMP", 8'd0};
         3'd6:    s = {"LAST_VISIT_", "TIMESTAMP"};
         default: s = '0;
      endcase
      i = p - 5'd1;
      if (p == 5'd0 || p == key_len(f) + 5'd1) begin
         return CH_QUOTE;
      end
      if (p > 5'd20) begin
         return 8'd0;
      end
      return s[8*(19 - i) +: 8];
   endfunction

   function automatic logic is_ws4(input logic [7:0] c);
      return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13;
   endfunction

   function automatic logic is_ws6(input logic [7:0] c);
      return is_ws4(c) || c == 8'd11 || c == 8'd12;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

endpackage

### hdl/association_record_field_extractor.sv
// ----------------------------------------------------------------------------
// association_record_field_extractor
// Streaming extractor of seven fields from one JSON-like record.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle and may return a registered result: a
// captured character of a string field, or a summary (status and the four
// numbers) when a transaction marks end of payload. Every transaction passes
// through the parse register stage; the byte-to-byte loop runs through the
// parse state and the decimal accumulator (a multiply by ten done as two
// shifts and an add). A one-entry output register with a skid entry lets a
// new transaction enter while a result still waits, so the block sustains
// one byte per cycle unless the result side stalls.
`include "association_record_field_extractor_macros.svh"

module association_record_field_extractor #(
   parameter int TEXT_LIMIT_MAX = arfe_pkg::TEXT_LIMIT_MAX_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  arfe_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output arfe_pkg::rsp_payload_type rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [3:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   // Configuration registers.
   logic [7:0] ssn_max_ff, name_max_ff, surname_max_ff;
   logic       cfg_wr;
   logic [1:0] cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite;
   assign cfg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ssn_max_ff     <= 8'd16;
         name_max_ff    <= 8'd31;
         surname_max_ff <= 8'd31;
      end else if (cfg_wr) begin
         case (cfg_idx)
            arfe_pkg::REG_SSN:     ssn_max_ff     <= pwdata[7:0];
            arfe_pkg::REG_NAME:    name_max_ff    <= pwdata[7:0];
            arfe_pkg::REG_SURNAME: surname_max_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (cfg_idx)
         arfe_pkg::REG_SSN:     prdata[7:0] = ssn_max_ff;
         arfe_pkg::REG_NAME:    prdata[7:0] = name_max_ff;
         arfe_pkg::REG_SURNAME: prdata[7:0] = surname_max_ff;
         default:               prdata      = '0;
      endcase
      if (paddr[1:0] != 2'd0) begin
         prdata = '0;
      end
   end

   // Parse state.
   logic [5:0]         phase_ff, phase_in;
   logic [4:0]         kpos_ff, kpos_in;
   logic [32:0]        acc_ff, acc_in;
   logic               minus_ff, minus_in;
   logic               digits_ff, digits_in;
   logic [7:0]         tcount_ff, tcount_in;
   logic [3:0]         err_ff, err_in;
   logic [31:0]        pat_ff, pat_in, tri_ff, tri_in, rec_ff, rec_in, lvt_ff, lvt_in;

   // Output register and skid entry.
   logic                      out_valid_ff, skid_valid_ff;
   arfe_pkg::rsp_payload_type out_ff, skid_ff;
   logic                      res_valid;
   arfe_pkg::rsp_payload_type res;
   logic                      accept;

   assign req_ready   = ~skid_valid_ff;
   assign accept      = req_valid & req_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   logic [7:0]  c;
   logic [2:0]  f, sub;
   logic [7:0]  lim_raw, lim;
   logic [35:0] acc_x10;
   logic [35:0] acc_next;
   logic [31:0] num_s;
   logic        num_ok;
   logic [3:0]  fail_code;
   logic        do_fail;

   always_comb begin
      c   = req_payload.data_byte;
      f   = phase_ff[5:3];
      sub = phase_ff[2:0];
      case (f)
         3'd1:    lim_raw = ssn_max_ff;
         3'd2:    lim_raw = name_max_ff;
         default: lim_raw = surname_max_ff;
      endcase
      lim = (32'(lim_raw) > TEXT_LIMIT_MAX) ? 8'(TEXT_LIMIT_MAX) : lim_raw;
      acc_x10  = ({3'd0, acc_ff} << 3) + ({3'd0, acc_ff} << 1);
      acc_next = acc_x10 + 36'(c - 8'd48);
      // Signed saturated value and unsigned check of the pending number.
      if (minus_ff) begin
         num_s = (acc_ff > 33'h080000000) ? 32'h80000000 : 32'(0) - acc_ff[31:0];
      end else begin
         num_s = (acc_ff > 33'h07FFFFFFF) ? 32'h7FFFFFFF : acc_ff[31:0];
      end
      num_ok = !((minus_ff && acc_ff != 33'd0) || acc_ff[32]);
   end

   // Next parse state and result for one byte; store a finished number; report rejection for timestamp fields.
   always_comb begin
      phase_in  = phase_ff;
      kpos_in   = kpos_ff;
      acc_in    = acc_ff;
      minus_in  = minus_ff;
      digits_in = digits_ff;
      tcount_in = tcount_ff;
      err_in    = err_ff;
      pat_in    = pat_ff;
      tri_in    = tri_ff;
      rec_in    = rec_ff;
      lvt_in    = lvt_ff;
      res_valid = 1'b0;
      res       = '0;
      do_fail   = 1'b0;
      fail_code = arfe_pkg::ST_OK;

      if (req_payload.end_of_payload) begin
         // Summary: judge the pending step as if the text stopped.
         if (phase_ff != arfe_pkg::PH_DONE && phase_ff != arfe_pkg::PH_TAIL && f <= 3'd6) begin
            case (sub)
               arfe_pkg::SUB_KEY:   begin do_fail = 1'b1; fail_code = arfe_pkg::ST_KEY_MISSING; end
               arfe_pkg::SUB_COLON: begin do_fail = 1'b1; fail_code = arfe_pkg::ST_COLON; end
               arfe_pkg::SUB_WS: begin
                  do_fail   = 1'b1;
                  fail_code = (f >= 3'd1 && f <= 3'd3) ? arfe_pkg::ST_NOT_STRING
                                                       : arfe_pkg::ST_NO_DIGITS;
               end
               arfe_pkg::SUB_VALUE: begin
                  do_fail = 1'b1;
                  if (f >= 3'd1 && f <= 3'd3) fail_code = arfe_pkg::ST_UNTERM;
                  else if (!digits_ff) fail_code = arfe_pkg::ST_NO_DIGITS;
                  else if (f == 3'd0) begin pat_in = num_s; fail_code = arfe_pkg::ST_COMMA; end
                  else if (f == 3'd4) begin tri_in = num_s; fail_code = arfe_pkg::ST_COMMA; end
                  else if (!num_ok) fail_code = arfe_pkg::ST_TOO_LARGE;
                  else if (f == 3'd5) begin rec_in = acc_ff[31:0]; fail_code = arfe_pkg::ST_COMMA; end
                  else begin lvt_in = acc_ff[31:0]; fail_code = arfe_pkg::ST_BRACE; end
               end
               arfe_pkg::SUB_AFTER: begin
                  do_fail   = 1'b1;
                  fail_code = (f == 3'd6) ? arfe_pkg::ST_BRACE : arfe_pkg::ST_COMMA;
               end
               default: ;
            endcase
         end
         res_valid           = 1'b1;
         res.result_kind     = arfe_pkg::RK_SUMMARY;
         res.status          = do_fail ? fail_code : err_ff;
         res.patient_number  = pat_in;
         res.triage_value    = tri_in;
         res.reception_time  = rec_in;
         res.last_visit_time = lvt_in;
         do_fail   = 1'b0;
         phase_in  = '0;
         kpos_in   = '0;
         acc_in    = '0;
         minus_in  = 1'b0;
         digits_in = 1'b0;
         tcount_in = '0;
         err_in    = arfe_pkg::ST_OK;
         pat_in    = '0;
         tri_in    = '0;
         rec_in    = '0;
         lvt_in    = '0;
      end else if (phase_ff == arfe_pkg::PH_DONE) begin
         phase_in = phase_ff;
      end else if (c == 8'd0) begin
         // Zero byte ends the text.
         if (phase_ff == arfe_pkg::PH_TAIL || f > 3'd6) begin
            phase_in = arfe_pkg::PH_DONE;
         end else begin
            do_fail = 1'b1;
            case (sub)
               arfe_pkg::SUB_KEY:   fail_code = arfe_pkg::ST_KEY_MISSING;
               arfe_pkg::SUB_COLON: fail_code = arfe_pkg::ST_COLON;
               arfe_pkg::SUB_WS:
                  fail_code = (f >= 3'd1 && f <= 3'd3) ? arfe_pkg::ST_NOT_STRING
                                                       : arfe_pkg::ST_NO_DIGITS;
               arfe_pkg::SUB_VALUE: begin
                  if (f >= 3'd1 && f <= 3'd3) fail_code = arfe_pkg::ST_UNTERM;
                  else if (!digits_ff) fail_code = arfe_pkg::ST_NO_DIGITS;
                  else if (f == 3'd0) begin pat_in = num_s; fail_code = arfe_pkg::ST_COMMA; end
                  else if (f == 3'd4) begin tri_in = num_s; fail_code = arfe_pkg::ST_COMMA; end
                  else if (!num_ok) fail_code = arfe_pkg::ST_TOO_LARGE;
                  else if (f == 3'd5) begin rec_in = acc_ff[31:0]; fail_code = arfe_pkg::ST_COMMA; end
                  else begin lvt_in = acc_ff[31:0]; fail_code = arfe_pkg::ST_BRACE; end
               end
               arfe_pkg::SUB_AFTER:
                  fail_code = (f == 3'd6) ? arfe_pkg::ST_BRACE : arfe_pkg::ST_COMMA;
               default: begin
                  do_fail  = 1'b0;
                  phase_in = arfe_pkg::PH_DONE;
               end
            endcase
         end
      end else if (phase_ff == arfe_pkg::PH_TAIL) begin
         if (!arfe_pkg::is_ws4(c)) begin
            do_fail   = 1'b1;
            fail_code = arfe_pkg::ST_TRAILING;
         end
      end else if (f > 3'd6) begin
         phase_in = arfe_pkg::PH_DONE;
      end else begin
         case (sub)
            arfe_pkg::SUB_KEY: begin
               if (kpos_ff <= arfe_pkg::key_len(f) + 5'd1 &&
                   c == arfe_pkg::key_char(f, kpos_ff)) begin
                  kpos_in = kpos_ff + 5'd1;
                  if (kpos_ff + 5'd1 == arfe_pkg::key_len(f) + 5'd2) begin
                     phase_in = {f, arfe_pkg::SUB_COLON};
                  end
               end else begin
                  kpos_in = (c == arfe_pkg::CH_QUOTE) ? 5'd1 : 5'd0;
               end
            end
            arfe_pkg::SUB_COLON: begin
               if (c == 8'd58) begin
                  phase_in  = {f, arfe_pkg::SUB_WS};
                  acc_in    = '0;
                  minus_in  = 1'b0;
                  digits_in = 1'b0;
               end
            end
            arfe_pkg::SUB_WS: begin
               if (f >= 3'd1 && f <= 3'd3) begin
                  if (arfe_pkg::is_ws4(c)) begin
                     phase_in = phase_ff;
                  end else if (c == arfe_pkg::CH_QUOTE) begin
                     phase_in  = {f, arfe_pkg::SUB_VALUE};
                     tcount_in = '0;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = arfe_pkg::ST_NOT_STRING;
                  end
               end else if (arfe_pkg::is_ws6(c)) begin
                  phase_in = phase_ff;
               end else if (c == 8'd43 || c == 8'd45) begin
                  minus_in = (c == 8'd45);
                  phase_in = {f, arfe_pkg::SUB_VALUE};
               end else if (arfe_pkg::is_digit(c)) begin
                  acc_in    = 33'(c - 8'd48);
                  digits_in = 1'b1;
                  phase_in  = {f, arfe_pkg::SUB_VALUE};
               end else begin
                  do_fail   = 1'b1;
                  fail_code = arfe_pkg::ST_NO_DIGITS;
               end
            end
            arfe_pkg::SUB_VALUE, arfe_pkg::SUB_AFTER: begin
               if (sub == arfe_pkg::SUB_VALUE && f >= 3'd1 && f <= 3'd3) begin
                  if (c == arfe_pkg::CH_QUOTE) begin
                     phase_in = {f, arfe_pkg::SUB_AFTER};
                  end else if (tcount_ff >= lim) begin
                     do_fail   = 1'b1;
                     fail_code = arfe_pkg::ST_TOO_LONG;
                  end else begin
                     tcount_in       = tcount_ff + 8'd1;
                     res_valid       = 1'b1;
                     res.result_kind = arfe_pkg::RK_CHAR;
                     res.text_field  = 2'(f - 3'd1);
                     res.text_byte   = c;
                  end
               end else if (sub == arfe_pkg::SUB_VALUE && arfe_pkg::is_digit(c)) begin
                  acc_in    = (acc_next > 36'h100000000) ? 33'h100000000 : acc_next[32:0];
                  digits_in = 1'b1;
               end else if (sub == arfe_pkg::SUB_VALUE && !digits_ff) begin
                  do_fail   = 1'b1;
                  fail_code = arfe_pkg::ST_NO_DIGITS;
               end else begin
                  // Finish the number (value sub-phase), then check separator.
                  if (sub == arfe_pkg::SUB_VALUE) begin
                     if (f == 3'd0) pat_in = num_s;
                     else if (f == 3'd4) tri_in = num_s;
                     else if (!num_ok) begin
                        do_fail   = 1'b1;
                        fail_code = arfe_pkg::ST_TOO_LARGE;
                     end else if (f == 3'd5) rec_in = acc_ff[31:0];
                     else lvt_in = acc_ff[31:0];
                  end
                  if (!do_fail) begin
                     if (arfe_pkg::is_ws4(c)) begin
                        phase_in = {f, arfe_pkg::SUB_AFTER};
                     end else if (f == 3'd6) begin
                        if (c == 8'd125) begin
                           phase_in = arfe_pkg::PH_TAIL;
                        end else begin
                           do_fail   = 1'b1;
                           fail_code = arfe_pkg::ST_BRACE;
                        end
                     end else if (c == 8'd44) begin
                        phase_in = {f + 3'd1, arfe_pkg::SUB_KEY};
                        kpos_in  = '0;
                     end else begin
                        do_fail   = 1'b1;
                        fail_code = arfe_pkg::ST_COMMA;
                     end
                  end
               end
            end
            default: phase_in = arfe_pkg::PH_DONE;
         endcase
      end

      if (do_fail) begin
         err_in   = fail_code;
         phase_in = arfe_pkg::PH_DONE;
      end
   end

   // Advance parse state on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         kpos_ff   <= '0;
         acc_ff    <= '0;
         minus_ff  <= 1'b0;
         digits_ff <= 1'b0;
         tcount_ff <= '0;
         err_ff    <= arfe_pkg::ST_OK;
         pat_ff    <= '0;
         tri_ff    <= '0;
         rec_ff    <= '0;
         lvt_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         kpos_ff   <= kpos_in;
         acc_ff    <= acc_in;
         minus_ff  <= minus_in;
         digits_ff <= digits_in;
         tcount_ff <= tcount_in;
         err_ff    <= err_in;
         pat_ff    <= pat_in;
         tri_ff    <= tri_in;
         rec_ff    <= rec_in;
         lvt_ff    <= lvt_in;
      end
   end

   // Output register with skid entry: hold a result while the consumer stalls.
   logic push;
   assign push = accept & res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_ready) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= push;
            end else begin
               out_valid_ff <= push;
            end
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
            if (push) skid_ff <= res;
         end else if (push) begin
            out_ff <= res;
         end
      end else if (push) begin
         skid_ff <= res;
      end
   end

   `ARFE_ASSERT_IMPL(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff,
                     "skid entry full while output empty")
   `ARFE_ASSERT_NEXT(a_summary_clears, clock, reset,
                     accept && req_payload.end_of_payload,
                     phase_ff == 6'd0 && err_ff == arfe_pkg::ST_OK,
                     "parse state not cleared after summary")
   `ARFE_ASSERT_IMPL(a_char_in_value, clock, reset, push && res.result_kind == arfe_pkg::RK_CHAR,
                     sub == arfe_pkg::SUB_VALUE,
                     "character emitted outside a string value")
   `ARFE_ASSERT_NEXT(a_done_sticks, clock, reset,
                     phase_ff == arfe_pkg::PH_DONE && !(accept && req_payload.end_of_payload),
                     phase_ff == arfe_pkg::PH_DONE,
                     "done phase left without end of payload")

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the association record field extractor.
// ----------------------------------------------------------------------------
// Feeds records byte by byte: a handful of short directed payloads, then
// random records. Most records are well formed with random whitespace,
// strings and numbers. The rest are damaged, truncated, cut short by a zero
// byte, given trailing data, or are plain noise. A scoreboard predicts every
// character and summary transaction and checks each one, field by field,
// against the block. Between phases the three string limits are rewritten
// over the configuration port while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

   localparam int IDLE_SETTLE = 6;

   // Predicts the block transaction by transaction and holds the results it
   // still owes.
   class record_scoreboard;
      bit [7:0]  limit_reg[3];
      bit [5:0]  phase;
      bit [4:0]  key_pos;
      bit [63:0] acc;
      bit        minus, got_digit;
      bit [7:0]  text_cnt;
      bit [3:0]  err;
      bit [31:0] patient, triage, reception, last_visit;
      arfe_pkg::rsp_payload_type owed[$];
      int        errors, char_cnt, summary_cnt, bad_cnt;
      string     keys[7];

      function new();
         keys = '{string'({"PATIENT_", "ID"}), "SSN", "NAME", "SURNAME",
                  string'({"TRIAGE_", "CODE"}), string'({"RECEPTION_", "TIMESTAMP"}),
                  string'({"LAST_VISIT_", "TIMESTAMP"})};
         limit_reg = '{8'd16, 8'd31, 8'd31};
         clear_record();
      endfunction

      function void clear_record();
         phase = 0; key_pos = 0; text_cnt = 0; err = arfe_pkg::ST_OK; acc = 0;
         minus = 0; got_digit = 0;
         patient = 0; triage = 0; reception = 0; last_visit = 0;
      endfunction

      function void stop(bit [3:0] code);
         err = code;
         phase = arfe_pkg::PH_DONE;
      endfunction

      function bit space4(bit [7:0] c);
         return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13;
      endfunction

      function bit [7:0] key_at(int f, int p);
         if (p == 0 || p == keys[f].len() + 1) begin
            return arfe_pkg::CH_QUOTE;
         end
         return keys[f][p - 1];
      endfunction

      // Close a number; zero when a timestamp was rejected.
      function bit close_number(int f);
         bit [31:0] v;
         if (f == 0 || f == 4) begin
            if (minus) begin
               v = acc > 64'h8000_0000 ? 32'h8000_0000 : 32'(0 - acc[31:0]);
            end else begin
               v = acc > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : acc[31:0];
            end
            if (f == 0) begin
               patient = v;
            end else begin
               triage = v;
            end
            return 1;
         end
         if ((minus && acc != 0) || acc > 64'hFFFF_FFFF) begin
            stop(arfe_pkg::ST_TOO_LARGE);
            return 0;
         end
         if (f == 5) begin
            reception = acc[31:0];
         end else begin
            last_visit = acc[31:0];
         end
         return 1;
      endfunction

      function void past_value(int f, bit [7:0] c);
         if (space4(c)) begin
            phase = 6'(f * 8 + arfe_pkg::SUB_AFTER);
         end else if (f == 6) begin
            if (c == 8'h7D) begin
               phase = arfe_pkg::PH_TAIL;
            end else begin
               stop(arfe_pkg::ST_BRACE);
            end
         end else if (c == 8'h2C) begin
            phase = 6'((f + 1) * 8 + arfe_pkg::SUB_KEY);
            key_pos = 0;
         end else begin
            stop(arfe_pkg::ST_COMMA);
         end
      endfunction

      function void text_stops();
         int f, sub;
         f = phase >> 3;
         sub = phase & 7;
         if (phase == arfe_pkg::PH_TAIL || f > 6) begin
            phase = arfe_pkg::PH_DONE;
         end else if (sub == arfe_pkg::SUB_KEY) begin
            stop(arfe_pkg::ST_KEY_MISSING);
         end else if (sub == arfe_pkg::SUB_COLON) begin
            stop(arfe_pkg::ST_COLON);
         end else if (sub == arfe_pkg::SUB_WS) begin
            stop((f >= 1 && f <= 3) ? arfe_pkg::ST_NOT_STRING : arfe_pkg::ST_NO_DIGITS);
         end else if (sub == arfe_pkg::SUB_VALUE) begin
            if (f >= 1 && f <= 3) begin
               stop(arfe_pkg::ST_UNTERM);
            end else if (!got_digit) begin
               stop(arfe_pkg::ST_NO_DIGITS);
            end else if (close_number(f)) begin
               stop(f == 6 ? arfe_pkg::ST_BRACE : arfe_pkg::ST_COMMA);
            end
         end else if (sub == arfe_pkg::SUB_AFTER) begin
            stop(f == 6 ? arfe_pkg::ST_BRACE : arfe_pkg::ST_COMMA);
         end else begin
            phase = arfe_pkg::PH_DONE;
         end
      endfunction

      // Advance the prediction by one accepted input transaction.
      function void note_input(arfe_pkg::req_payload_type t);
         arfe_pkg::rsp_payload_type r;
         bit [7:0] c;
         int f, sub;
         c = t.data_byte;
         r = '0;
         if (t.end_of_payload) begin
            if (phase != arfe_pkg::PH_DONE) begin
               text_stops();
            end
            r.result_kind = arfe_pkg::RK_SUMMARY;
            r.status = err;
            r.patient_number = patient;
            r.triage_value = triage;
            r.reception_time = reception;
            r.last_visit_time = last_visit;
            owed.push_back(r);
            clear_record();
            return;
         end
         if (phase == arfe_pkg::PH_DONE) return;
         if (c == 0) begin
            text_stops();
            return;
         end
         if (phase == arfe_pkg::PH_TAIL) begin
            if (!space4(c)) stop(arfe_pkg::ST_TRAILING);
            return;
         end
         f = phase >> 3;
         sub = phase & 7;
         if (f > 6) begin
            phase = arfe_pkg::PH_DONE;
         end else if (sub == arfe_pkg::SUB_KEY) begin
            if (key_pos <= keys[f].len() + 1 && c == key_at(f, key_pos)) begin
               key_pos++;
               if (key_pos == keys[f].len() + 2) phase = 6'(f * 8 + arfe_pkg::SUB_COLON);
            end else begin
               key_pos = (c == arfe_pkg::CH_QUOTE) ? 5'd1 : 5'd0;
            end
         end else if (sub == arfe_pkg::SUB_COLON) begin
            if (c == 8'h3A) begin
               phase = 6'(f * 8 + arfe_pkg::SUB_WS);
               acc = 0; minus = 0; got_digit = 0;
            end
         end else if (sub == arfe_pkg::SUB_WS) begin
            if (f >= 1 && f <= 3) begin
               if (space4(c)) return;
               if (c == arfe_pkg::CH_QUOTE) begin
                  phase = 6'(f * 8 + arfe_pkg::SUB_VALUE);
                  text_cnt = 0;
               end else begin
                  stop(arfe_pkg::ST_NOT_STRING);
               end
            end else begin
               if (space4(c) || c == 8'd11 || c == 8'd12) return;
               if (c == 8'h2B || c == 8'h2D) begin
                  minus = (c == 8'h2D);
                  phase = 6'(f * 8 + arfe_pkg::SUB_VALUE);
               end else if (c >= 8'h30 && c <= 8'h39) begin
                  acc = 64'(c - 8'h30);
                  got_digit = 1;
                  phase = 6'(f * 8 + arfe_pkg::SUB_VALUE);
               end else begin
                  stop(arfe_pkg::ST_NO_DIGITS);
               end
            end
         end else if (sub == arfe_pkg::SUB_VALUE) begin
            if (f >= 1 && f <= 3) begin
               if (c == arfe_pkg::CH_QUOTE) begin
                  phase = 6'(f * 8 + arfe_pkg::SUB_AFTER);
               end else if (text_cnt >= limit_reg[f - 1]) begin
                  stop(arfe_pkg::ST_TOO_LONG);
               end else begin
                  text_cnt++;
                  r.result_kind = arfe_pkg::RK_CHAR;
                  r.text_field = 2'(f - 1);
                  r.text_byte = c;
                  owed.push_back(r);
               end
            end else if (c >= 8'h30 && c <= 8'h39) begin
               acc = acc * 10 + 64'(c - 8'h30);
               if (acc > 64'h1_0000_0000) acc = 64'h1_0000_0000;
               got_digit = 1;
            end else if (!got_digit) begin
               stop(arfe_pkg::ST_NO_DIGITS);
            end else if (close_number(f)) begin
               past_value(f, c);
            end
         end else if (sub == arfe_pkg::SUB_AFTER) begin
            past_value(f, c);
         end else begin
            phase = arfe_pkg::PH_DONE;
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      // Compare one result transaction with the oldest one owed.
      task check_result(arfe_pkg::rsp_payload_type got);
         arfe_pkg::rsp_payload_type e;
         if (owed.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
         end
         e = owed.pop_front();
         if (e.result_kind == arfe_pkg::RK_SUMMARY) begin
            summary_cnt++;
            if (e.status != arfe_pkg::ST_OK) bad_cnt++;
         end else begin
            char_cnt++;
         end
         if (got.result_kind != e.result_kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.result_kind, e.result_kind));
         if (got.text_field != e.text_field)
            report_mismatch($sformatf("text_field %0d, want %0d", got.text_field, e.text_field));
         if (got.text_byte != e.text_byte)
            report_mismatch($sformatf("text_byte %h, want %h", got.text_byte, e.text_byte));
         if (got.status != e.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, e.status));
         if (got.patient_number != e.patient_number)
            report_mismatch($sformatf("patient %0d, want %0d",
                                      got.patient_number, e.patient_number));
         if (got.triage_value != e.triage_value)
            report_mismatch($sformatf("triage %0d, want %0d",
                                      got.triage_value, e.triage_value));
         if (got.reception_time != e.reception_time)
            report_mismatch($sformatf("reception %0d, want %0d",
                                      got.reception_time, e.reception_time));
         if (got.last_visit_time != e.last_visit_time)
            report_mismatch($sformatf("last_visit %0d, want %0d",
                                      got.last_visit_time, e.last_visit_time));
      endtask
   endclass

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_valid = 0;
   logic                      req_ready;
   arfe_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 0;
   arfe_pkg::rsp_payload_type rsp_payload;
   logic                      psel = 0, penable = 0, pwrite = 0;
   logic [3:0]                paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   record_scoreboard          sb = new();
   arfe_pkg::req_payload_type bytes_out[$];
   int                        burst_left = 0;
   int                        sent_cnt = 0;
   bit                        hold_off = 0;   // main asks the receiver for one long stall
   int                        record_cnt = 0;

   association_record_field_extractor uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("timeout at %0t", $time);
      $display("FAIL");
      $finish;
   end

   // Monitor both channels on the edge itself; check results before noting
   // the new input so the order within a step never matters.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_payload);
         if (req_valid && req_ready) sb.note_input(req_payload);
      end
   end

   // Receiver: switch stall pattern every so often; honor a long hold-off.
   initial begin : receiver
      int mode, span, held;
      mode = 0; span = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < 300; held++) @(posedge clock);
            hold_off = 0;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
         end
         span--;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Offer one input transaction and hold it until accepted. Gaps fall
   // between bursts of random length.
   task automatic send(arfe_pkg::req_payload_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (!req_ready);
      sent_cnt++;
   endtask

   task automatic flush_bytes();
      while (bytes_out.size() != 0) send(bytes_out.pop_front());
   endtask

   // Drop valid, drain every owed result, then let in-flight work settle.
   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= {24'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      sb.limit_reg[idx] = val;
   endtask

   task automatic set_limits(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      csr_write(arfe_pkg::REG_SSN, a);
      csr_write(arfe_pkg::REG_NAME, b);
      csr_write(arfe_pkg::REG_SURNAME, c);
   endtask

   function automatic void put_byte(logic [7:0] b, logic eop);
      arfe_pkg::req_payload_type t;
      t.data_byte = b;
      t.end_of_payload = eop;
      bytes_out.push_back(t);
   endfunction

   function automatic void put_text(string s);
      foreach (s[i]) put_byte(s[i], 1'b0);
   endfunction

   function automatic string blanks(bit before_number);
      string s;
      byte   pick[6];
      int    n;
      pick = '{8'd32, 8'd9, 8'd10, 8'd13, 8'd11, 8'd12};
      s = "";
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) s = {s, string'(pick[$urandom_range(0, before_number ? 5 : 3)])};
      return s;
   endfunction

   function automatic string number_text();
      case ($urandom_range(0, 9))
         0: return $sformatf("-%0d", $urandom);
         1: return "2147483648";
         2: return "-2147483649";
         3: return "4294967295";
         4: return "4294967296";
         5: return "99999999999999999999";
         6: return "-0";
         7: return ($urandom_range(0, 1) == 0) ? "+" : "-";
         8: return $sformatf("+%0d", $urandom_range(0, 999));
         default: return $sformatf("%0d", $urandom);
      endcase
   endfunction

   function automatic string string_text(int most);
      string s;
      byte   c;
      s = "";
      repeat ($urandom_range(0, most)) begin
         c = byte'($urandom_range(1, 255));
         if (c == arfe_pkg::CH_QUOTE) c = 8'h41;
         s = {s, string'(c)};
      end
      return s;
   endfunction

   // Build one record; damage some of them, then close the payload.
   function automatic void put_record(int text_most);
      string rec;
      int    k, pos, n;
      rec = {blanks(0), "{"};
      for (k = 0; k < 7; k++) begin
         rec = {rec, blanks(0), "\"", sb.keys[k], "\"", blanks(0), ":"};
         if (k >= 1 && k <= 3) begin
            rec = {rec, blanks(0), "\"", string_text(text_most), "\""};
         end else begin
            rec = {rec, blanks(1), number_text()};
         end
         rec = {rec, blanks(0), (k == 6) ? "}" : ","};
      end
      rec = {rec, blanks(0)};
      case ($urandom_range(0, 9))
         0: begin
            pos = $urandom_range(0, rec.len() - 1);
            rec[pos] = byte'($urandom_range(1, 255));
         end
         1: rec = rec.substr(0, $urandom_range(0, rec.len() - 2));
         2: rec = {rec, "x"};
         default: ;
      endcase
      put_text(rec);
      if ($urandom_range(0, 9) == 0) begin
         // zero byte ends the text; anything behind it is ignored
         pos = $urandom_range(0, bytes_out.size());
         n = bytes_out.size();
         put_byte(8'd0, 1'b0);
         bytes_out.insert(pos, bytes_out[n]);
         bytes_out.delete(n + 1);
      end
      put_byte(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   initial begin : stimulus
      int lim_a, lim_b, lim_c, phase_no, n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty payload, zero byte, all-ones byte, keys with no value.
      put_byte(8'hFF, 1'b1);
      put_byte(8'h00, 1'b1);
      put_byte(8'hFF, 1'b0);
      put_byte(8'h00, 1'b1);
      put_text(string'({"{\"PATIENT_", "ID\""}));
      put_byte(8'h00, 1'b1);
      put_text(string'({"}\"PATIENT_", "ID\":x"}));
      put_byte(8'hFF, 1'b1);
      flush_bytes();
      go_idle();

      // Random phases, each with its own string limits.
      for (phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            0: begin lim_a = 16; lim_b = 31; lim_c = 31; end
            1: begin lim_a = 0; lim_b = 0; lim_c = 0; end
            2: begin lim_a = 255; lim_b = 255; lim_c = 255; end
            3: begin lim_a = 1; lim_b = 254; lim_c = 3; end
            default: begin
               lim_a = $urandom_range(0, 255);
               lim_b = $urandom_range(0, 40);
               lim_c = $urandom_range(0, 40);
            end
         endcase
         set_limits(8'(lim_a), 8'(lim_b), 8'(lim_c));
         // long strings with the receiver held off fill the block
         if (phase_no == 2) hold_off = 1;
         n = sent_cnt + 160;
         while (sent_cnt < n) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise that never forms a record
               repeat ($urandom_range(1, 30)) put_byte(8'($urandom_range(0, 255)), 1'b0);
               put_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
               put_record(phase_no == 2 ? 300 : 20);
            end
            record_cnt++;
            flush_bytes();
         end
         go_idle();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d input transactions, %0d records, %0d string characters",
               sent_cnt, record_cnt, sb.char_cnt);
      $display("%0d summaries checked, %0d with an error status", sb.summary_cnt,
               sb.bad_cnt);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

### association_record_field_extractor.f
+incdir+hdl
hdl/arfe_pkg.sv
hdl/association_record_field_extractor.sv
verif/testbench.sv
